[rtl/lfu_pkg.sv]
// ----------------------------------------------------------------------------
// lfu_pkg
// shared types, codes and defaults for the lfu cache table
// ----------------------------------------------------------------------------
`default_nettype none

package lfu_pkg;

    localparam int DEF_ENTRIES    = 16;
    localparam int DEF_COUNT_BITS = 16;

    localparam int KEY_W  = 32;
    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // request kinds
    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    typedef struct packed {
        logic                     mode;
        logic signed [KEY_W-1:0]  lookup_key;
        logic signed [DATA_W-1:0] write_value;
    } req_t;

    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] read_value;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic scan;
        logic decide;
        logic upd;
        logic load_rsp;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic issue_done;
        logic pipe_empty;
        logic need_update;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

[rtl/lfu_cache_table_top.sv]
// ----------------------------------------------------------------------------
// lfu_cache_table_top
// fully associative key/value store with least-frequently-used replacement
// and least-recently-used tie break
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake            payload
//   s_        in         s_valid / s_ready    lfu_pkg::req_t (mode, key, value)
//   m_        out        m_valid / m_ready    lfu_pkg::rsp_t (hit, read_value)
//   cfg_      in         cfg_wr_en            capacity_limit, 5 bits
//
// one request at a time; with N occupied slots: a scan pass over the N slots, plan,
// an update pass over M slots (M = N, or N + 1 for an insert into a free slot) and a
// result register load, from transfer to result; the update pass is skipped with no
// update; each pass reads one slot per cycle on the slot memory's read port
// reset is synchronous active low; it empties the table and sets capacity
// to 16, no clearing pass is needed since slots fill in index order
// a held result in the output register does not block the next transfer in
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_cache_table_top #(
    parameter int ENTRIES    = lfu_pkg::DEF_ENTRIES,
    parameter int COUNT_BITS = lfu_pkg::DEF_COUNT_BITS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // configuration
    input  logic                      cfg_wr_en,
    input  logic [lfu_pkg::CAP_W-1:0] cfg_wr_data,
    // request channel
    input  logic                      s_valid,
    output logic                      s_ready,
    input  lfu_pkg::req_t             s_data,
    // result channel
    output logic                      m_valid,
    input  logic                      m_ready,
    output lfu_pkg::rsp_t             m_data
);

    import lfu_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // sequencer: walks scan, plan, update and result hand-off
    lfu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // slot memory, match / victim search, write-back, result register
    lfu_datapath #(
        .ENTRIES    (ENTRIES),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .cmd         (cmd),
        .status      (status),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

`default_nettype wire

[rtl/lfu_ram.sv]
// ----------------------------------------------------------------------------
// lfu_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/lfu_datapath.sv]
// ----------------------------------------------------------------------------
// lfu_datapath
// slot memory, scan evaluation, update write-back and result register
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_datapath #(
    parameter int ENTRIES    = lfu_pkg::DEF_ENTRIES,
    parameter int COUNT_BITS = lfu_pkg::DEF_COUNT_BITS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [lfu_pkg::CAP_W-1:0] cfg_wr_data,
    input  lfu_pkg::req_t            s_data,
    input  lfu_pkg::ctrl_cmd_t       cmd,
    output lfu_pkg::dp_status_t      status,
    output logic                     m_valid,
    input  logic                     m_ready,
    output lfu_pkg::rsp_t            m_data
);

    import lfu_pkg::*;

    localparam int AW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OW   = $clog2(ENTRIES + 1);
    localparam int CMPW = (OW > CAP_W) ? OW : CAP_W;

    typedef struct packed {
        logic [KEY_W-1:0]      key;
        logic [DATA_W-1:0]     value;
        logic [COUNT_BITS-1:0] cnt;
        logic [AW-1:0]         rank;
    } entry_t;

    localparam int EW = $bits(entry_t);

    logic [CAP_W-1:0]      cap_reg;
    logic [OW-1:0]         occ_reg, occ_next;
    req_t                  req_reg;
    logic [OW-1:0]         idx_reg, idx_next;
    logic [OW-1:0]         end_reg, end_next;
    logic                  rd_vld_reg;
    logic [AW-1:0]         rd_addr_reg;
    logic                  found_reg;
    logic [AW-1:0]         found_idx_reg;
    logic [AW-1:0]         found_rank_reg;
    logic [DATA_W-1:0]     found_val_reg;
    logic                  vic_any_reg;
    logic [AW-1:0]         vic_idx_reg;
    logic [COUNT_BITS-1:0] vic_cnt_reg;
    logic [AW-1:0]         vic_rank_reg;
    logic [AW-1:0]         tgt_reg;
    logic [AW-1:0]         thr_reg;
    logic                  bump_all_reg;
    logic                  replace_reg;
    logic                  m_valid_reg, m_valid_next;
    rsp_t                  m_data_reg;

    logic                  rd_issue;
    logic [EW-1:0]         ram_rdata;
    entry_t                rd_entry;
    entry_t                wr_entry;
    logic                  ram_we;
    logic                  is_put;
    logic                  key_match;
    logic                  vic_better;
    logic [CMPW-1:0]       cap_eff;
    logic [CMPW-1:0]       cap_ext;
    logic                  plan_go;
    logic                  plan_insert;
    logic                  plan_replace;
    logic                  plan_bump_all;
    logic [AW-1:0]         plan_tgt;
    logic [AW-1:0]         plan_thr;
    rsp_t                  rsp_comb;

    assign is_put   = (req_reg.mode == MODE_PUT);
    assign rd_entry = entry_t'(ram_rdata);
    assign rd_issue = (cmd.scan || cmd.upd) && (idx_reg != end_reg);

    lfu_ram #(
        .WIDTH (EW),
        .DEPTH (ENTRIES)
    ) u_slot_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (rd_addr_reg),
        .wdata (wr_entry),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // scan evaluation
    assign key_match  = rd_vld_reg && cmd.scan && (rd_entry.key == $unsigned(req_reg.lookup_key));
    assign vic_better = !vic_any_reg || (rd_entry.cnt < vic_cnt_reg) ||
                        ((rd_entry.cnt == vic_cnt_reg) && (rd_entry.rank > vic_rank_reg));

    // plan after the scan
    assign cap_ext = CMPW'(cap_reg);
    assign cap_eff = (cap_ext > CMPW'(ENTRIES)) ? CMPW'(ENTRIES) : cap_ext;

    always_comb begin
        plan_go       = 1'b0;
        plan_insert   = 1'b0;
        plan_replace  = 1'b0;
        plan_bump_all = 1'b0;
        plan_tgt      = found_idx_reg;
        plan_thr      = found_rank_reg;
        priority if (!is_put) begin
            plan_go = found_reg;
        end else if (cap_eff == '0) begin
            plan_go = 1'b0;
        end else if (found_reg) begin
            plan_go = 1'b1;
        end else if (CMPW'(occ_reg) < cap_eff) begin
            plan_go       = 1'b1;
            plan_insert   = 1'b1;
            plan_replace  = 1'b1;
            plan_bump_all = 1'b1;
            plan_tgt      = occ_reg[AW-1:0];
        end else begin
            plan_go      = 1'b1;
            plan_replace = 1'b1;
            plan_tgt     = vic_idx_reg;
            plan_thr     = vic_rank_reg;
        end
    end

    always_comb begin
        rsp_comb.hit        = found_reg;
        rsp_comb.read_value = (!is_put && found_reg) ? $signed(found_val_reg) : '0;
    end

    // read-modify-write of one slot per cycle in the update pass
    assign ram_we = cmd.upd && rd_vld_reg;

    always_comb begin
        wr_entry = rd_entry;
        if (rd_addr_reg == tgt_reg) begin
            if (replace_reg) begin
                wr_entry.key = $unsigned(req_reg.lookup_key);
                wr_entry.cnt = COUNT_BITS'(1);
            end else if (rd_entry.cnt != {COUNT_BITS{1'b1}}) begin
                wr_entry.cnt = rd_entry.cnt + COUNT_BITS'(1);
            end
            if (is_put) begin
                wr_entry.value = $unsigned(req_reg.write_value);
            end
            wr_entry.rank = '0;
        end else if (bump_all_reg || (rd_entry.rank < thr_reg)) begin
            wr_entry.rank = rd_entry.rank + AW'(1);
        end
    end

    always_comb begin
        idx_next = idx_reg;
        end_next = end_reg;
        occ_next = occ_reg;
        if (cmd.capture) begin
            idx_next = '0;
            end_next = occ_reg;
        end else if (cmd.decide) begin
            idx_next = '0;
            if (plan_insert) begin
                end_next = occ_reg + OW'(1);
                occ_next = occ_reg + OW'(1);
            end
        end else if (rd_issue) begin
            idx_next = idx_reg + OW'(1);
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_rsp) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= CAP_RESET;
            occ_reg     <= '0;
            idx_reg     <= '0;
            end_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            occ_reg     <= occ_next;
            idx_reg     <= idx_next;
            end_reg     <= end_next;
            rd_vld_reg  <= rd_issue;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_addr_reg <= idx_reg[AW-1:0];
        if (cmd.capture) begin
            req_reg     <= s_data;
            found_reg   <= 1'b0;
            vic_any_reg <= 1'b0;
        end
        if (key_match && !found_reg) begin
            found_reg      <= 1'b1;
            found_idx_reg  <= rd_addr_reg;
            found_rank_reg <= rd_entry.rank;
            found_val_reg  <= rd_entry.value;
        end
        if (rd_vld_reg && cmd.scan && vic_better) begin
            vic_any_reg  <= 1'b1;
            vic_idx_reg  <= rd_addr_reg;
            vic_cnt_reg  <= rd_entry.cnt;
            vic_rank_reg <= rd_entry.rank;
        end
        if (cmd.decide) begin
            tgt_reg      <= plan_tgt;
            thr_reg      <= plan_thr;
            bump_all_reg <= plan_bump_all;
            replace_reg  <= plan_replace;
        end
        if (cmd.load_rsp) begin
            m_data_reg <= rsp_comb;
        end
    end

    assign status.issue_done  = (idx_reg == end_reg);
    assign status.pipe_empty  = !rd_vld_reg;
    assign status.need_update = plan_go;
    assign status.out_free    = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

[rtl/lfu_ctrl.sv]
// ----------------------------------------------------------------------------
// lfu_ctrl
// request sequencer: scan pass, plan, update pass, result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lfu_pkg::dp_status_t status,
    output lfu_pkg::ctrl_cmd_t  cmd
);

    import lfu_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_UPD    = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
                if (s_valid) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (status.issue_done && status.pipe_empty) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = status.need_update ? S_UPD : S_DONE;
            end
            S_UPD: begin
                cmd.upd = 1'b1;
                if (status.issue_done && status.pipe_empty) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                cmd.load_rsp = status.out_free;
                if (status.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[rtl/lfu_checker.sv]
// ----------------------------------------------------------------------------
// lfu_port_checker
// port-level checks on the lfu cache table, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_port_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input lfu_pkg::rsp_t m_data
);

    // one request in flight: ready drops right after a transfer in
    a_busy_after_xfer: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("s_ready still high after request transfer");

    // a new result only appears while no request is being taken
    a_rsp_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared without a request in flight");

    // a miss result carries zero read data
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.hit) |-> (m_data.read_value == '0))
        else $error("miss result carries nonzero read_value");

    // stalled result holds
    a_rsp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result changed or dropped");

endmodule

bind lfu_cache_table_top lfu_port_checker u_port_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
